// File: design/sha_pkg.sv
// Shared types, constants and round functions for the SHA-256 compression core.
`default_nettype none

package sha_pkg;

	localparam int unsigned ROUNDS       = 64;
	localparam int unsigned BLOCK_WORDS  = 16;
	localparam int unsigned DIGEST_WORDS = 8;

	typedef logic [31:0] word_t;

	// One input item: a word of the padded message and its framing flags.
	typedef struct packed {
		word_t message_word;
		logic  first_of_message;
		logic  last_of_message;
	} msg_item_t;

	// One result item: a word of the final digest.
	typedef struct packed {
		word_t       digest_word;
		logic [2:0]  digest_index;
		logic        last_word;
	} digest_item_t;

	// Classified command handed from the front end to the hashing back end.
	typedef struct packed {
		word_t word;
		logic  reload;
		logic  compress;
		logic  emit;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUNDS,
		ST_FINAL,
		ST_EMIT
	} core_state_t;

	// Standard initial hash values.
	function automatic word_t init_hash(input logic [2:0] idx);
		word_t v;
		case (idx)
			3'd0:    v = 32'h6a09e667;
			3'd1:    v = 32'hbb67ae85;
			3'd2:    v = 32'h3c6ef372;
			3'd3:    v = 32'ha54ff53a;
			3'd4:    v = 32'h510e527f;
			3'd5:    v = 32'h9b05688c;
			3'd6:    v = 32'h1f83d9ab;
			default: v = 32'h5be0cd19;
		endcase
		return v;
	endfunction

	// Round constants.
	function automatic word_t round_k(input logic [5:0] idx);
		word_t v;
		case (idx)
			6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
			6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
			6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
			6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
			6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
			6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
			6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
			6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
			6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
			6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
			6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
			6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
			6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
			6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
			6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
			6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
			6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
			6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
			6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
			6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
			6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
			6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
			6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
			6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
			6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
			6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
			6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
			6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
			6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
			6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
			6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
			6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
		endcase
		return v;
	endfunction

	function automatic word_t big_sigma0(input word_t v);
		return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
	endfunction

	function automatic word_t big_sigma1(input word_t v);
		return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
	endfunction

	function automatic word_t small_sigma0(input word_t v);
		return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
	endfunction

	function automatic word_t small_sigma1(input word_t v);
		return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'b0, v[31:10]};
	endfunction

	function automatic word_t choose(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic word_t majority(input word_t x, input word_t y, input word_t z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

`default_nettype wire

// File: design/sha_front.sv
// Front end: accepts message items, tracks block position and queues commands.
`default_nettype none

module sha_front #(
	parameter int unsigned DEPTH = 4
) (
	input  wire                logic        clk,
	input  wire                logic        arst_n,
	input  wire                logic        msg_valid,
	output                     logic        msg_stall,
	input  wire sha_pkg::msg_item_t         msg_item,
	output                     logic        cmd_valid,
	input  wire                logic        cmd_take,
	output sha_pkg::cmd_t                   cmd_item
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [3:0]     wc_q;
	logic [3:0]     wc_base;
	logic [3:0]     wc_next;
	sha_pkg::cmd_t  new_cmd;
	sha_pkg::cmd_t  queue_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	// Handshakes on both sides of the queue.
	assign msg_stall = (count_q == CW'(DEPTH));
	assign push      = msg_valid & ~msg_stall;
	assign cmd_valid = (count_q != '0);
	assign pop       = cmd_valid & cmd_take;
	assign cmd_item  = queue_q[rd_ptr_q];

	// Classify the item by its place in the block.
	always_comb begin
		wc_base           = msg_item.first_of_message ? 4'd0 : wc_q;
		wc_next           = msg_item.last_of_message ? 4'd0 : wc_base + 4'd1;
		new_cmd.word      = msg_item.message_word;
		new_cmd.reload    = msg_item.first_of_message;
		new_cmd.compress  = (wc_base == 4'd15);
		new_cmd.emit      = msg_item.last_of_message;
	end

	// Word counter and queue pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q     <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wc_q     <= wc_next;
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_cmd;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill exceeds its depth");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("queue fill did not grow on a lone push");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push && msg_item.last_of_message) |=> wc_q == 4'd0)
		else $error("block position not cleared after last item");

endmodule

`default_nettype wire

// File: design/sha_core.sv
// Back end: message schedule, round unit, chaining hash and digest output.
`default_nettype none

module sha_core (
	input  wire                  logic  clk,
	input  wire                  logic  arst_n,
	input  wire                  logic  cmd_valid,
	output                       logic  cmd_take,
	input  wire sha_pkg::cmd_t          cmd_item,
	output                       logic  dig_valid,
	input  wire                  logic  dig_stall,
	output sha_pkg::digest_item_t       dig_item
);

	sha_pkg::core_state_t   state_q;
	sha_pkg::core_state_t   state_next;
	logic [5:0]             round_q;
	logic [2:0]             idx_q;
	logic                   emit_q;
	sha_pkg::word_t         window_q [sha_pkg::BLOCK_WORDS];
	sha_pkg::word_t         work_q   [sha_pkg::DIGEST_WORDS];
	sha_pkg::word_t         chain_q  [sha_pkg::DIGEST_WORDS];
	logic                   out_valid_q;
	sha_pkg::digest_item_t  out_item_q;
	logic                   pop;
	logic                   out_load;
	logic                   round_run;
	sha_pkg::word_t         w_new;
	sha_pkg::word_t         t1;
	sha_pkg::word_t         t2;

	assign pop       = cmd_valid & cmd_take;
	assign dig_valid = out_valid_q;
	assign dig_item  = out_item_q;

	// Next state.
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			sha_pkg::ST_IDLE: begin
				if (pop && cmd_item.compress) begin
					state_next = sha_pkg::ST_ROUNDS;
				end else if (pop && cmd_item.emit) begin
					state_next = sha_pkg::ST_EMIT;
				end
			end
			sha_pkg::ST_ROUNDS: begin
				if (round_q == 6'(sha_pkg::ROUNDS - 1)) begin
					state_next = sha_pkg::ST_FINAL;
				end
			end
			sha_pkg::ST_FINAL: begin
				state_next = emit_q ? sha_pkg::ST_EMIT : sha_pkg::ST_IDLE;
			end
			sha_pkg::ST_EMIT: begin
				if (out_load && idx_q == 3'd7) begin
					state_next = sha_pkg::ST_IDLE;
				end
			end
			default: state_next = sha_pkg::ST_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		cmd_take  = (state_q == sha_pkg::ST_IDLE);
		round_run = (state_q == sha_pkg::ST_ROUNDS);
		out_load  = (state_q == sha_pkg::ST_EMIT) && (!out_valid_q || !dig_stall);
	end

	// One round: next schedule word and the two temporaries.
	always_comb begin
		w_new = sha_pkg::small_sigma1(window_q[14]) + window_q[9]
			+ sha_pkg::small_sigma0(window_q[1]) + window_q[0];
		t1 = work_q[7] + sha_pkg::big_sigma1(work_q[4])
			+ sha_pkg::choose(work_q[4], work_q[5], work_q[6])
			+ sha_pkg::round_k(round_q) + window_q[0];
		t2 = sha_pkg::big_sigma0(work_q[0])
			+ sha_pkg::majority(work_q[0], work_q[1], work_q[2]);
	end

	// Control registers and chaining hash.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha_pkg::ST_IDLE;
			round_q     <= '0;
			idx_q       <= '0;
			emit_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
				chain_q[i] <= sha_pkg::init_hash(3'(i));
			end
		end else begin
			state_q <= state_next;
			if (round_run) begin
				round_q <= round_q + 6'd1;
			end
			if (pop) begin
				emit_q <= cmd_item.emit;
			end
			if (out_load) begin
				idx_q       <= idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!dig_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && cmd_item.reload) begin
				for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
					chain_q[i] <= sha_pkg::init_hash(3'(i));
				end
			end else if (state_q == sha_pkg::ST_FINAL) begin
				for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
					chain_q[i] <= chain_q[i] + work_q[i];
				end
			end
		end
	end

	// Schedule window, working values and output register.
	always_ff @(posedge clk) begin
		if (pop || round_run) begin
			for (int i = 0; i < sha_pkg::BLOCK_WORDS - 1; i++) begin
				window_q[i] <= window_q[i + 1];
			end
			window_q[sha_pkg::BLOCK_WORDS - 1] <= pop ? cmd_item.word : w_new;
		end
		if (pop && cmd_item.compress) begin
			for (int i = 0; i < sha_pkg::DIGEST_WORDS; i++) begin
				work_q[i] <= cmd_item.reload ? sha_pkg::init_hash(3'(i)) : chain_q[i];
			end
		end else if (round_run) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
		if (out_load) begin
			out_item_q.digest_word  <= chain_q[idx_q];
			out_item_q.digest_index <= idx_q;
			out_item_q.last_word    <= (idx_q == 3'd7);
		end
	end

	a_round_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != sha_pkg::ST_ROUNDS |-> round_q == 6'd0)
		else $error("round counter not at zero outside the rounds");

	a_final_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sha_pkg::ST_FINAL |-> $past(state_q) == sha_pkg::ST_ROUNDS)
		else $error("final add reached without running the rounds");

	a_emit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && idx_q == 3'd7) |=> (state_q == sha_pkg::ST_IDLE && out_valid_q
			&& idx_q == 3'd0))
		else $error("digest emission did not end cleanly");

endmodule

`default_nettype wire

// File: design/sha256_compression.sv
// A plain word moves from the queue into the schedule window once the back end is idle;
// a word that completes a block also runs the rounds and then the chaining add in ST_FINAL.
// The single round unit takes no new command while busy; the queue accepts items until full.
// A last item gives eight digest items from the output register, one per cycle unless stalled.
// Reset clears the queue and controls and loads the chaining hash with the initial values;
// the schedule window has no reset and there is no clearing pass.
`default_nettype none

module sha256_compression #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire                  logic  clk,
	input  wire                  logic  arst_n,
	input  wire                  logic  msg_valid,
	output                       logic  msg_stall,
	input  wire sha_pkg::msg_item_t     msg_item,
	output                       logic  dig_valid,
	input  wire                  logic  dig_stall,
	output sha_pkg::digest_item_t       dig_item
);

	logic           cmd_valid;
	logic           cmd_take;
	sha_pkg::cmd_t  cmd_item;

	// Front end and its command queue.
	sha_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_item  (msg_item),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_item  (cmd_item)
	);

	// Hashing back end.
	sha_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_take  (cmd_take),
		.cmd_item  (cmd_item),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_item  (dig_item)
	);

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the SHA-256 compression core, with a built-in hash predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 100;
	localparam int RANDOM_WORDS   = 190;
	localparam int CALM_AFTER     = 150;
	localparam int N_DIRECTED     = 21;

	// Directed row: one message word, its flags, and whether the digest is the initial hash.
	typedef struct packed {
		sha_pkg::word_t word;
		logic           first;
		logic           last;
		logic           iv_digest;
	} row_t;

	// Shapes of the random messages.
	typedef enum int {
		SHAPE_FULL,
		SHAPE_CHAINED,
		SHAPE_CUT,
		SHAPE_NOISE,
		SHAPE_SINGLE
	} msg_shape_t;

	localparam logic [0:7][31:0] INIT_WORDS = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [0:63][31:0] KROUND = {
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// Both flags on one word, a lone last flag, a cut block, the padded "abc" block, then a lone last flag.
	localparam row_t [0:N_DIRECTED-1] DIRECTED = {
		{32'hffffffff, 1'b1, 1'b1, 1'b1},
		{32'h00000000, 1'b0, 1'b1, 1'b1},
		{32'h80000000, 1'b1, 1'b0, 1'b0},
		{32'h00000001, 1'b0, 1'b1, 1'b1},
		{32'h61626380, 1'b1, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000000, 1'b0, 1'b0, 1'b0},
		{32'h00000018, 1'b0, 1'b1, 1'b0},
		{32'ha5a5a5a5, 1'b0, 1'b1, 1'b0}
	};

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  msg_valid = 1'b0;
	logic                  msg_stall;
	sha_pkg::msg_item_t    msg_item  = '0;
	logic                  dig_valid;
	logic                  dig_stall = 1'b0;
	sha_pkg::digest_item_t dig_item;

	// Predictor state.
	sha_pkg::word_t        chain_words [8];
	sha_pkg::word_t        window_words [16];
	logic [3:0]            fill_count;
	sha_pkg::digest_item_t digest_q [$];
	sha_pkg::digest_item_t want_item;

	int  mismatches  = 0;
	int  idle_cycles = 0;
	int  stall_left  = 0;
	int  sent_words  = 0;
	bit  steady      = 1'b0;
	bit  calm_tail   = 1'b0;
	bit  stall_mode  = 1'b1;

	sha256_compression dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_item  (msg_item),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_item  (dig_item)
	);

	always #2 clk = ~clk;

	function automatic sha_pkg::word_t rotr(input sha_pkg::word_t x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic sha_pkg::word_t ep0(input sha_pkg::word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic sha_pkg::word_t ep1(input sha_pkg::word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic sha_pkg::word_t sg0(input sha_pkg::word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic sha_pkg::word_t sg1(input sha_pkg::word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic sha_pkg::word_t ch_fn(input sha_pkg::word_t x, input sha_pkg::word_t y,
		input sha_pkg::word_t z);
		return (x & y) ^ (~x & z);
	endfunction

	function automatic sha_pkg::word_t maj_fn(input sha_pkg::word_t x, input sha_pkg::word_t y,
		input sha_pkg::word_t z);
		return (x & y) ^ (x & z) ^ (y & z);
	endfunction

	// Expand the window in place over 64 rounds and add the result into the chain.
	task automatic compress_block();
		sha_pkg::word_t v [8];
		sha_pkg::word_t w;
		sha_pkg::word_t t1;
		sha_pkg::word_t t2;
		logic [3:0]     s;
		int             r;
		int             i;
		for (i = 0; i < 8; i++) v[i] = chain_words[i];
		for (r = 0; r < 64; r++) begin
			s = r[3:0];
			if (r >= 16) begin
				window_words[s] = window_words[s] + sg0(window_words[s + 4'd1])
					+ window_words[s + 4'd9] + sg1(window_words[s + 4'd14]);
			end
			w  = window_words[s];
			t1 = v[7] + ep1(v[4]) + ch_fn(v[4], v[5], v[6]) + KROUND[r] + w;
			t2 = ep0(v[0]) + maj_fn(v[0], v[1], v[2]);
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++) chain_words[i] = chain_words[i] + v[i];
	endtask

	// Apply one accepted word to the predictor and queue the digest it causes.
	task automatic absorb_word(input sha_pkg::msg_item_t it, input bit iv_digest);
		sha_pkg::digest_item_t d;
		int                    i;
		if (it.first_of_message) begin
			for (i = 0; i < 8; i++) chain_words[i] = INIT_WORDS[i];
			fill_count = '0;
		end
		window_words[fill_count] = it.message_word;
		fill_count = fill_count + 4'd1;
		if (fill_count == 4'd0) compress_block();
		if (it.last_of_message) begin
			fill_count = '0;
			for (i = 0; i < 8; i++) begin
				d.digest_word  = iv_digest ? sha_pkg::word_t'(INIT_WORDS[i]) : chain_words[i];
				d.digest_index = i[2:0];
				d.last_word    = (i == 7);
				digest_q.push_back(d);
			end
		end
	endtask

	// Offer one item, with an occasional gap before it, and wait until it is taken.
	task automatic send_word(input sha_pkg::msg_item_t it, input bit iv_digest);
		int gap;
		bit taken;
		gap = 0;
		if (!calm_tail && !steady && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 3);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg_item  <= it;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = (msg_stall === 1'b0);
			@(posedge clk);
		end
		absorb_word(it, iv_digest);
		sent_words++;
		if (sent_words >= CALM_AFTER) calm_tail = 1'b1;
	endtask

	// Hold the input side idle until every queued digest item has come out.
	task automatic drain_digests();
		msg_valid <= 1'b0;
		do @(posedge clk); while (digest_q.size() != 0);
	endtask

	function automatic sha_pkg::word_t pick_word();
		sha_pkg::word_t w;
		case ($urandom_range(0, 7))
			0:       w = '0;
			1:       w = '1;
			2:       w = 32'h80000000;
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// A run of words with an optional first flag and the last flag on the final word.
	task automatic send_run(input int nwords, input bit with_first);
		sha_pkg::msg_item_t it;
		int                 i;
		for (i = 0; i < nwords; i++) begin
			it.message_word     = pick_word();
			it.first_of_message = with_first && (i == 0);
			it.last_of_message  = (i == nwords - 1);
			send_word(it, 1'b0);
		end
	endtask

	// Words with flags scattered at random.
	task automatic send_noise(input int nwords);
		sha_pkg::msg_item_t it;
		int                 i;
		for (i = 0; i < nwords; i++) begin
			it.message_word     = pick_word();
			it.first_of_message = ($urandom_range(0, 7) == 0);
			it.last_of_message  = ($urandom_range(0, 7) == 0);
			send_word(it, 1'b0);
		end
	endtask

	// Receiver stalls in short random bursts, with calm stretches and none at the end.
	always @(posedge clk) begin
		if ($urandom_range(0, 39) == 0) stall_mode = ~stall_mode;
		if (calm_tail || !stall_mode) begin
			stall_left = 0;
			dig_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			dig_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(0, 2);
			dig_stall <= 1'b1;
		end else begin
			dig_stall <= 1'b0;
		end
	end

	// Compare each digest item taken from the block with the oldest expected one.
	always @(negedge clk) begin
		if (arst_n && dig_valid === 1'b1 && dig_stall === 1'b0) begin
			if (digest_q.size() == 0) begin
				$display("%0t: unexpected digest item, expected none, actual %h", $time, dig_item);
				mismatches++;
			end else begin
				want_item = digest_q.pop_front();
				if (dig_item.digest_word !== want_item.digest_word) begin
					$display("%0t: digest_word expected %h actual %h", $time,
						want_item.digest_word, dig_item.digest_word);
					mismatches++;
				end
				if (dig_item.digest_index !== want_item.digest_index) begin
					$display("%0t: digest_index expected %0d actual %0d", $time,
						want_item.digest_index, dig_item.digest_index);
					mismatches++;
				end
				if (dig_item.last_word !== want_item.last_word) begin
					$display("%0t: last_word expected %b actual %b", $time,
						want_item.last_word, dig_item.last_word);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves an item.
	always @(negedge clk) begin
		if ((msg_valid && msg_stall === 1'b0) || (dig_valid === 1'b1 && !dig_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired, %0d digest items still expected", $time,
				digest_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	// Main sequence: reset, directed table, random messages, drain.
	initial begin
		sha_pkg::msg_item_t it;
		msg_shape_t         shape;
		int                 pick;
		int                 k;
		for (k = 0; k < 8; k++) chain_words[k] = INIT_WORDS[k];
		for (k = 0; k < 16; k++) window_words[k] = '0;
		fill_count = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table.
		steady = ($urandom_range(0, 1) == 0);
		for (k = 0; k < N_DIRECTED; k++) begin
			it.message_word     = DIRECTED[k].word;
			it.first_of_message = DIRECTED[k].first;
			it.last_of_message  = DIRECTED[k].last;
			send_word(it, DIRECTED[k].iv_digest);
		end
		drain_digests();

		// Random messages, mostly well formed.
		while (sent_words < N_DIRECTED + RANDOM_WORDS) begin
			steady = ($urandom_range(0, 2) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 11)      shape = SHAPE_FULL;
			else if (pick < 13) shape = SHAPE_CHAINED;
			else if (pick < 15) shape = SHAPE_CUT;
			else if (pick < 18) shape = SHAPE_NOISE;
			else                shape = SHAPE_SINGLE;
			case (shape)
				SHAPE_FULL:    send_run(($urandom_range(0, 3) == 0) ? 32 : 16, 1'b1);
				SHAPE_CHAINED: send_run(16, 1'b0);
				SHAPE_CUT:     send_run($urandom_range(1, 15), 1'b1);
				SHAPE_NOISE:   send_noise($urandom_range(1, 20));
				default:       send_run(1, 1'b1);
			endcase
			if (digest_q.size() != 0 && $urandom_range(0, 3) == 0) drain_digests();
		end

		drain_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// File: sim.f
design/sha_pkg.sv
design/sha_front.sv
design/sha_core.sv
design/sha256_compression.sv
tb/sv/tb_top.sv
